/* rtl/core/i2cm_pkg.sv */
// Shared types, codes and reset constants for the I2C master bit engine.
package i2cm_pkg;

  localparam int unsigned STRETCH_BITS_DEF = 24;
  localparam int unsigned PHASE_W          = 16;
  localparam int unsigned LIMIT_W          = 24;
  localparam int unsigned CFG_DATA_W       = 24;
  localparam int unsigned CFG_IDX_W        = 1;

  localparam logic [PHASE_W-1:0] PHASE_TICKS_RST   = 16'd100;
  localparam logic [LIMIT_W-1:0] STRETCH_LIMIT_RST = 24'd50000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_TICKS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRETCH_LIMIT = 1'd1;

  // Bus commands
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_WACK  = 3'd5,
    CMD_SACK  = 3'd6,
    CMD_RSVD  = 3'd7
  } cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       ack_level;
    logic       scl_sense;
    logic       sda_sense;
  } in_item_t;

  typedef struct packed {
    logic       scl_drive;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       timeout;
  } out_item_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase_ticks;
    logic [LIMIT_W-1:0] stretch_limit;
  } cfg_t;

endpackage

/* rtl/core/i2cm_in_if.sv */
// Tick channel into the bit engine: valid/ready plus one tick item.
interface i2cm_in_if import i2cm_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

/* rtl/core/i2cm_out_if.sv */
// Result channel out of the bit engine: valid/ready plus one result item.
interface i2cm_out_if import i2cm_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

/* rtl/core/i2cm_core.sv */
// Bus sequencer state and its single-tick next-state logic.
module i2cm_core import i2cm_pkg::*; #(
  parameter int unsigned STRETCH_BITS = STRETCH_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t res
);

  typedef enum logic [12:0] {
    PH_IDLE   = 13'b0000000000001,
    PH_ST_HI  = 13'b0000000000010,
    PH_ST_D1  = 13'b0000000000100,
    PH_ST_D2  = 13'b0000000001000,
    PH_ST_D3  = 13'b0000000010000,
    PH_SP_D1  = 13'b0000000100000,
    PH_SP_HI  = 13'b0000001000000,
    PH_SP_D2  = 13'b0000010000000,
    PH_SP_D3  = 13'b0000100000000,
    PH_B_SET  = 13'b0001000000000,
    PH_B_HI   = 13'b0010000000000,
    PH_B_HOLD = 13'b0100000000000,
    PH_B_LO   = 13'b1000000000000
  } phase_t;

  phase_t                  phase_r,   phase_nxt;
  logic [2:0]              acmd_r,    acmd_nxt;
  logic [3:0]              bcnt_r,    bcnt_nxt;
  logic [7:0]              shift_r,   shift_nxt;
  logic                    ackc_r,    ackc_nxt;
  logic [PHASE_W-1:0]      delay_r,   delay_nxt;
  logic [STRETCH_BITS-1:0] stretch_r, stretch_nxt;
  logic                    scl_r,     scl_nxt;
  logic                    sda_r,     sda_nxt;
  logic [7:0]              rx_r,      rx_nxt;
  logic                    ack_r,     ack_nxt;

  logic [STRETCH_BITS-1:0] limit;
  logic [STRETCH_BITS-1:0] stretch_inc;
  logic                    go;
  phase_t                  tgt;
  logic                    cmpl;
  logic                    fin;
  logic                    tmo;

  // Effective limit: low STRETCH_BITS bits of the register, zero-extended when STRETCH_BITS exceeds LIMIT_W
  generate
    if (STRETCH_BITS <= LIMIT_W) begin : g_lim_trunc
      assign limit = cfg.stretch_limit[STRETCH_BITS-1:0];
    end else begin : g_lim_ext
      assign limit = {{(STRETCH_BITS-LIMIT_W){1'b0}}, cfg.stretch_limit};
    end
  endgenerate

  assign stretch_inc = stretch_r + 1'b1;

  always_comb begin
    phase_nxt   = phase_r;
    acmd_nxt    = acmd_r;
    bcnt_nxt    = bcnt_r;
    shift_nxt   = shift_r;
    ackc_nxt    = ackc_r;
    delay_nxt   = delay_r;
    stretch_nxt = stretch_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    rx_nxt      = rx_r;
    ack_nxt     = ack_r;
    go          = 1'b0;
    tgt         = PH_IDLE;
    cmpl        = 1'b0;
    fin         = 1'b0;
    tmo         = 1'b0;

    if (step) begin
      case (phase_r)
        PH_IDLE: begin
          if (item.cmd inside {[CMD_START:CMD_SACK]}) begin
            acmd_nxt  = item.cmd;
            bcnt_nxt  = 4'd0;
            ackc_nxt  = item.ack_level;
            shift_nxt = 8'd0;
            go        = 1'b1;
            case (item.cmd)
              CMD_START: tgt = PH_ST_HI;
              CMD_STOP:  tgt = PH_SP_D1;
              CMD_WRITE: begin
                shift_nxt = item.tx_byte;
                sda_nxt   = item.tx_byte[7];
                tgt       = PH_B_SET;
              end
              CMD_READ: begin
                sda_nxt = 1'b1;
                tgt     = PH_B_HI;
              end
              CMD_WACK: begin
                sda_nxt = 1'b1;
                tgt     = PH_B_SET;
              end
              default: begin
                sda_nxt = ~item.ack_level;
                tgt     = PH_B_SET;
              end
            endcase
          end
        end
        PH_ST_HI, PH_SP_HI, PH_B_HI: begin
          if (item.scl_sense) begin
            cmpl = 1'b1;
          end else begin
            stretch_nxt = stretch_inc;
            if (stretch_inc >= limit) begin
              if (acmd_r == CMD_READ) begin
                rx_nxt = 8'd0;
              end else if (acmd_r == CMD_WACK) begin
                ack_nxt = 1'b1;
              end
              scl_nxt   = 1'b1;
              tmo       = 1'b1;
              fin       = 1'b1;
              phase_nxt = PH_IDLE;
              acmd_nxt  = CMD_NONE;
            end
          end
        end
        default: begin
          if (delay_r <= PHASE_W'(1)) begin
            cmpl = 1'b1;
          end else begin
            delay_nxt = delay_r - 1'b1;
          end
        end
      endcase

      if (cmpl) begin
        go = 1'b1;
        case (phase_r)
          PH_ST_HI: tgt = PH_ST_D1;
          PH_ST_D1: tgt = PH_ST_D2;
          PH_ST_D2: tgt = PH_ST_D3;
          PH_SP_D1: tgt = PH_SP_HI;
          PH_SP_HI: tgt = PH_SP_D2;
          PH_SP_D2: tgt = PH_SP_D3;
          PH_B_SET: tgt = PH_B_HI;
          PH_B_HI:  tgt = PH_B_HOLD;
          PH_B_HOLD: begin
            if (acmd_r == CMD_READ && bcnt_r < 4'd8) begin
              shift_nxt = {shift_r[6:0], item.sda_sense};
              bcnt_nxt  = bcnt_r + 1'b1;
            end else if (acmd_r == CMD_WACK) begin
              ack_nxt = item.sda_sense;
            end
            tgt = PH_B_LO;
          end
          PH_B_LO: begin
            if (acmd_r == CMD_WRITE) begin
              bcnt_nxt = bcnt_r + 1'b1;
              if (bcnt_nxt < 4'd8) begin
                shift_nxt = {shift_r[6:0], 1'b0};
                sda_nxt   = shift_r[6];
                tgt       = PH_B_SET;
              end else begin
                go = 1'b0;
              end
            end else if (acmd_r == CMD_READ) begin
              if (bcnt_r < 4'd8) begin
                tgt = PH_B_HI;
              end else if (bcnt_r == 4'd8) begin
                bcnt_nxt = 4'd9;
                sda_nxt  = ~ackc_r;
                tgt      = PH_B_SET;
              end else begin
                rx_nxt = shift_r;
                go     = 1'b0;
              end
            end else begin
              go = 1'b0;
            end
          end
          default: go = 1'b0;  // end of start or stop
        endcase
        if (!go) begin
          fin       = 1'b1;
          phase_nxt = PH_IDLE;
          acmd_nxt  = CMD_NONE;
        end
      end
    end

    // Phase entry: reload timers, apply the phase's line levels
    if (go) begin
      phase_nxt   = tgt;
      delay_nxt   = cfg.phase_ticks;
      stretch_nxt = '0;
      case (tgt)
        PH_ST_HI: begin
          sda_nxt = 1'b1;
          scl_nxt = 1'b1;
        end
        PH_ST_D2: sda_nxt = 1'b0;
        PH_ST_D3: scl_nxt = 1'b0;
        PH_SP_D1: sda_nxt = 1'b0;
        PH_SP_HI: scl_nxt = 1'b1;
        PH_SP_D3: sda_nxt = 1'b1;
        PH_B_HI:  scl_nxt = 1'b1;
        PH_B_LO:  scl_nxt = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      acmd_r    <= CMD_NONE;
      bcnt_r    <= 4'd0;
      shift_r   <= 8'd0;
      ackc_r    <= 1'b0;
      delay_r   <= '0;
      stretch_r <= '0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      rx_r      <= 8'd0;
      ack_r     <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      acmd_r    <= acmd_nxt;
      bcnt_r    <= bcnt_nxt;
      shift_r   <= shift_nxt;
      ackc_r    <= ackc_nxt;
      delay_r   <= delay_nxt;
      stretch_r <= stretch_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      rx_r      <= rx_nxt;
      ack_r     <= ack_nxt;
    end
  end

  assign res.scl_drive = scl_nxt;
  assign res.sda_drive = sda_nxt;
  assign res.busy_res  = (phase_nxt != PH_IDLE);
  assign res.done_res  = fin;
  assign res.rx_byte   = rx_nxt;
  assign res.ack_seen  = ack_nxt;
  assign res.timeout   = tmo;

endmodule

/* rtl/core/i2c_master_bit_engine_unit.sv */
// Top level of the I2C master bit engine: tick register, sequencer, result register.
//
// Use: every transfer on in_ch is one bus tick. It carries the sampled SCL and
// SDA levels and optionally a command (start, stop, write byte, read byte,
// wait ack, send ack/nack); a command is taken only while the engine is idle,
// otherwise ignored. Every tick yields exactly one result on out_ch: the SCL
// and SDA drive levels (1 = release), busy, a done pulse, the last read byte,
// the last ack level seen, and a timeout flag.
// cfg_we/cfg_index/cfg_data write phase_ticks (index 0) and stretch_limit
// (index 1); write only while idle.
// Path: a tick taken into the tick register passes through the sequencer into the
// result register, and its result transfers on out_ch from there.
// Throughput: one tick per cycle while out_ch is not held; the sequencer does one
// tick's work between the tick register and the result register.
// Reset (synchronous, rst_n low): both lines released, engine idle, read byte
// and ack level zero, phase_ticks 100, stretch_limit 50000, both stages empty.
// Stall: while out_ch is held, the result register holds; one more tick may
// wait in the tick register, then in_ch.ready drops until out_ch moves.
module i2c_master_bit_engine_unit import i2cm_pkg::*; #(
  parameter int unsigned STRETCH_BITS = STRETCH_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  i2cm_in_if.sink               in_ch,
  i2cm_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  cfg_t      cfg_r;

  // Tick register
  logic      tick_valid_r, tick_valid_nxt;
  in_item_t  tick_item_r;

  // Result register
  logic      res_valid_r, res_valid_nxt;
  out_item_t res_item_r;

  logic      in_xfer;
  logic      adv;        // tick stage hands its item to the sequencer
  out_item_t step_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_ticks   <= PHASE_TICKS_RST;
      cfg_r.stretch_limit <= STRETCH_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PHASE_TICKS:   cfg_r.phase_ticks   <= cfg_data[PHASE_W-1:0];
        REG_STRETCH_LIMIT: cfg_r.stretch_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv          = tick_valid_r && (!res_valid_r || out_ch.ready);
  assign in_ch.ready  = !tick_valid_r || adv;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  assign tick_valid_nxt = in_xfer || (tick_valid_r && !adv);
  assign res_valid_nxt  = adv || (res_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      tick_valid_r <= tick_valid_nxt;
      res_valid_r  <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      tick_item_r <= in_ch.item;
    end
    if (adv) begin
      res_item_r <= step_res;
    end
  end

  // Sequencer advances one tick per handed-over item
  i2cm_core #(
    .STRETCH_BITS (STRETCH_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (tick_item_r),
    .cfg   (cfg_r),
    .res   (step_res)
  );

  assign out_ch.valid = res_valid_r;
  assign out_ch.item  = res_item_r;

endmodule
